/* rtl/core/tolerance_search_list_core_assert.svh */
// assertion macros used by the port-level checker
`ifndef TOLERANCE_SEARCH_LIST_CORE_ASSERT_SVH
`define TOLERANCE_SEARCH_LIST_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tsl_pkg.sv */
// shared codes and types for the tolerance search list
package tsl_pkg;

  localparam int DATA_W  = 32;
  localparam int TOL_W   = 31;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  // update request from the decode logic to the entry store
  typedef struct packed {
    logic              append_en;
    logic              remove_en;
    logic [DATA_W-1:0] data;
  } tsl_ctl_t;

endpackage

/* rtl/core/tsl_lane.sv */
// one compare lane: is a stored entry within tolerance of the query
module tsl_lane
  import tsl_pkg::*;
(
  input  logic signed [DATA_W-1:0] entry,
  input  logic signed [DATA_W-1:0] value,
  input  logic        [TOL_W-1:0]  tolerance,
  input  logic                     active,
  output logic                     hit
);

  logic signed [DATA_W:0] diff;
  logic        [DATA_W:0] mag;

  always_comb begin
    // one bit wider so the difference never wraps
    diff = {entry[DATA_W-1], entry} - {value[DATA_W-1], value};
    mag  = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
    hit  = active && (mag <= {2'b00, tolerance});
  end

endmodule

/* rtl/core/tsl_store.sv */
// entry registers and count, with tail write and one-place shift down
module tsl_store
  import tsl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tsl_ctl_t                             ctl,
  input  logic [CAPACITY-1:0]                  rm_mask,
  output logic [CAPACITY-1:0][DATA_W-1:0]      entries,
  output logic [$clog2(CAPACITY+1)-1:0]        count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctl.append_en) begin
      count_next = count + CW'(1);
    end else if (ctl.remove_en) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    if (i < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (ctl.append_en && (CW'(i) == count)) begin
          entries[i] <= ctl.data;
        end else if (ctl.remove_en && rm_mask[i]) begin
          entries[i] <= entries[i+1];
        end
      end
    end else begin : g_last
      // the top entry only takes appends; after a remove it lies above the count
      always_ff @(posedge clk) begin
        if (ctl.append_en && (CW'(i) == count)) begin
          entries[i] <= ctl.data;
        end
      end
    end
  end

endmodule

/* rtl/core/tolerance_search_list_core.sv */
// tolerance search list: bounded ordered list with append, find and remove
// a transaction accepted into the request register shows its result (done high) from the result register
// throughput: one transaction per cycle; busy is low except during reset
// each transaction is decoded combinationally against the list from the request register
// reset clears the count and the pipeline valid bits; entry contents are left as they are
module tolerance_search_list_core
  import tsl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic [TOL_W-1:0]         tolerance,
  output logic                     done,
  output logic [1:0]               status,
  output logic [IDX_W-1:0]         match_index,
  output logic signed [DATA_W-1:0] removed_value,
  output logic [CNT_W-1:0]         entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request register
  logic                     req_valid;
  logic [1:0]               req_kind;
  logic signed [DATA_W-1:0] req_value;
  logic [TOL_W-1:0]         req_tol;

  logic [CAPACITY-1:0][DATA_W-1:0] entries;
  logic [CW-1:0]                   count;
  logic [CAPACITY-1:0]             hit_vec;
  logic [CAPACITY-1:0]             hit_first;
  logic [CAPACITY-1:0]             rm_mask;
  logic [IW-1:0]                   hit_idx;
  logic [DATA_W-1:0]               hit_data;
  logic                            any_hit;
  logic                            full;
  tsl_ctl_t                        ctl;

  logic [1:0]        status_next;
  logic [31:0]       idx_wide;
  logic [31:0]       cnt_wide;
  logic [DATA_W-1:0] removed_next;
  logic [CW-1:0]     count_after;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
    if (start && !busy) begin
      req_kind  <= kind;
      req_value <= value;
      req_tol   <= tolerance;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_lane
    tsl_lane u_lane (
      .entry     (entries[i]),
      .value     (req_value),
      .tolerance (req_tol),
      .active    (CW'(i) < count),
      .hit       (hit_vec[i])
    );
  end

  always_comb begin
    // lowest matching lane, then everything at or above it shifts on remove
    hit_first = hit_vec & (~hit_vec + CAPACITY'(1));
    rm_mask   = ~(hit_first - CAPACITY'(1));
    any_hit   = |hit_vec;
    hit_idx   = '0;
    hit_data  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_first[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_data = hit_data | entries[i];
      end
    end
    full = (count == CW'(CAPACITY));
  end

  always_comb begin
    ctl           = '0;
    ctl.data      = req_value;
    status_next   = STATUS_NOT_FOUND;
    idx_wide      = '0;
    removed_next  = '0;
    count_after   = count;
    case (req_kind)
      KIND_APPEND: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          status_next   = STATUS_OK;
          idx_wide      = 32'(count);
          ctl.append_en = req_valid;
          count_after   = count + CW'(1);
        end
      end
      KIND_FIND: begin
        if (any_hit) begin
          status_next = STATUS_OK;
          idx_wide    = 32'(hit_idx);
        end
      end
      KIND_REMOVE: begin
        if (any_hit) begin
          status_next   = STATUS_OK;
          idx_wide      = 32'(hit_idx);
          removed_next  = hit_data;
          ctl.remove_en = req_valid;
          count_after   = count - CW'(1);
        end
      end
      default: begin
        status_next = STATUS_NOT_FOUND;
      end
    endcase
    cnt_wide = 32'(count_after);
  end

  tsl_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rm_mask (rm_mask),
    .entries (entries),
    .count   (count)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
    status        <= status_next;
    match_index   <= idx_wide[IDX_W-1:0];
    removed_value <= removed_next;
    entry_count   <= cnt_wide[CNT_W-1:0];
  end

endmodule

/* rtl/core/tsl_checker.sv */
// port-level checker for the tolerance search list, bound to the top level
`include "tolerance_search_list_core_assert.svh"

module tsl_checker
  import tsl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [1:0]               status,
  input logic [IDX_W-1:0]         match_index,
  input logic [CNT_W-1:0]         entry_count
);

  // every accepted transaction yields exactly one result, through the request and result registers
  `TSL_ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, ##1 done, "result missing")
  `TSL_ASSERT_NEXT(a_no_spurious, clk, rst, !(start && !busy), ##1 !done, "unexpected result")
  `TSL_ASSERT_NOW(a_idx_zero_on_fail, clk, rst, done && (status != STATUS_OK),
    match_index == '0, "index not zero on failure")
  `TSL_ASSERT_NOW(a_full_count, clk, rst, done && (status == STATUS_FULL),
    entry_count == CNT_W'(CAPACITY), "full reported below capacity")

endmodule

bind tolerance_search_list_core tsl_checker #(.CAPACITY(CAPACITY)) u_tsl_checker (.*);
